[src/sqt_pkg.sv]
package sqt_pkg;

    localparam int DEF_COUNT_BITS = 8;
    localparam int DEF_ANGLE_BITS = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int SINE_SEGS      = 256;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic [15:0] RADIUS_RST  = 16'd256;
    localparam int          SECTORS_RST = 36;
    localparam int          STACKS_RST  = 18;

    typedef enum logic [1:0] {
        CFG_RADIUS  = 2'd0,
        CFG_SECTORS = 2'd1,
        CFG_STACKS  = 2'd2,
        CFG_WIRE    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic has_a;
        logic has_b;
        logic wire_mode;
    } t_quad_flags;

    typedef logic [15:0] t_sine_tab [0:SINE_SEGS];

    // quarter-wave Q1.15 sine, Q2.30 Taylor series
    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint sum;
        for (int k = 0; k <= SINE_SEGS; k++) begin
            x    = (64'(k) * PI_Q30) / 64'd512;
            term = x;
            sum  = signed'(x);
            x2   = (x * x) >> 30;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            q = (unsigned'(sum) + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            tab[k] = 16'(q);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

[src/sqt_recip.sv]
module sqt_recip import sqt_pkg::*; #(
    parameter int CB = DEF_COUNT_BITS,
    parameter int KW = DEF_COUNT_BITS + 1 + DEF_ANGLE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CB-1:0] i_div,
    output logic          o_busy,
    output logic [KW:0]   o_recip
);

    localparam int CW = $clog2(KW + 1);

    logic          r_act;
    logic [CW-1:0] r_cnt;
    logic [CB-1:0] r_rem;
    logic [KW:0]   r_quo;
    logic [CB:0]   t_val;
    logic          ge;
    logic [CB-1:0] n_rem;

    // restoring division of 2^KW by the count, one quotient bit a cycle
    always_comb begin
        t_val = {r_rem, (r_cnt == CW'(KW))};
        ge    = t_val >= {1'b0, i_div};
        n_rem = ge ? CB'(t_val - {1'b0, i_div}) : CB'(t_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_act <= 1'b1;
            r_cnt <= CW'(KW);
            r_rem <= '0;
        end else if (r_act) begin
            r_rem <= n_rem;
            if (r_cnt == '0) begin
                r_act <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_act) begin
            r_quo <= {r_quo[KW-1:0], ge};
        end
    end

    assign o_busy  = r_act;
    assign o_recip = r_quo;

endmodule

[src/sqt_fifo.sv]
module sqt_fifo import sqt_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    input  logic         i_pop,
    output logic [W-1:0] o_dout,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_dout  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

endmodule

[src/sqt_front.sv]
module sqt_front import sqt_pkg::*; #(
    parameter int CB = DEF_COUNT_BITS
) (
    input  logic          i_valid,
    input  logic [15:0]   i_data,
    input  logic [CB-1:0] i_sectors,
    input  logic [CB-1:0] i_stacks,
    input  logic          i_wire,
    input  logic          i_recip_busy,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output logic [CB-1:0] o_row,
    output logic [CB-1:0] o_col,
    output t_quad_flags   o_flags
);

    logic [CB+7:0] row_ext;
    logic [CB+7:0] col_ext;
    logic          in_range;

    always_comb begin
        row_ext           = {{CB{1'b0}}, i_data[7:0]};
        col_ext           = {{CB{1'b0}}, i_data[15:8]};
        o_row             = row_ext[CB-1:0];
        o_col             = col_ext[CB-1:0];
        o_ready           = !i_recip_busy && !i_q_full;
        in_range          = (o_row < i_stacks) && (o_col < i_sectors);
        o_flags.has_a     = o_row != '0;
        o_flags.has_b     = o_row != (i_stacks - 1'b1);
        o_flags.wire_mode = i_wire;
        o_push            = i_valid && o_ready && in_range && (o_flags.has_a || o_flags.has_b);
    end

endmodule

[src/sqt_back.sv]
module sqt_back import sqt_pkg::*; #(
    parameter int CB = DEF_COUNT_BITS,
    parameter int AB = DEF_ANGLE_BITS,
    parameter int KW = DEF_COUNT_BITS + 1 + DEF_ANGLE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  logic [CB-1:0] i_q_row,
    input  logic [CB-1:0] i_q_col,
    input  t_quad_flags   i_q_flags,
    output logic          o_q_pop,
    input  logic [15:0]   i_radius,
    input  logic [CB-1:0] i_sectors,
    input  logic [CB-1:0] i_stacks,
    input  logic [KW:0]   i_rec_sectors,
    input  logic [KW:0]   i_rec_stacks,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [55:0]   o_data,
    output logic          o_last
);

    localparam int SH = AB - 10;
    localparam int FW = (SH > 0) ? SH : 1;
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
    localparam logic [AB-2:0] QMAG    = (AB-1)'(1) << (AB - 2);

    function automatic logic [14:0] quarter_sine(input logic [AB-2:0] q);
        logic [8:0]     idx;
        logic [FW-1:0]  frac;
        logic [15:0]    a;
        logic [15:0]    b;
        logic [16+FW-1:0] prod;
        idx  = 9'(q >> SH);
        frac = FW'(q) & FW'((1 << SH) - 1);
        if (idx >= 9'(SINE_SEGS)) begin
            return SINE_TAB[SINE_SEGS][14:0];
        end
        a    = SINE_TAB[idx];
        b    = SINE_TAB[9'(idx + 1'b1)];
        prod = (b - a) * frac;
        return 15'(a + 16'(prod >> SH));
    endfunction

    // {negative, magnitude}
    function automatic logic [15:0] phase_sine(input logic [AB-1:0] p);
        logic [AB-2:0] q;
        q = {1'b0, p[AB-3:0]};
        if (p[AB-2]) begin
            q = QMAG - q;
        end
        return {p[AB-1], quarter_sine(q)};
    endfunction

    logic en;

    // vertex sequencer
    logic          r_busy;
    logic [CB-1:0] r_row;
    logic [CB-1:0] r_col;
    logic          r_has_b;
    logic          r_wire;
    logic          r_tri;
    logic [2:0]    r_w;
    logic          n_busy;
    logic          n_tri;
    logic [2:0]    n_w;
    logic          at_end;
    logic [1:0]    vtx;
    logic          ds;
    logic          dt;
    logic          load;

    always_comb begin
        at_end = r_w == (r_wire ? 3'd5 : 3'd4);
        if (r_wire) begin
            case (r_w)
                3'd1, 3'd2: vtx = 2'd1;
                3'd3, 3'd4: vtx = 2'd2;
                default:    vtx = 2'd0;
            endcase
        end else begin
            vtx = r_w[2:1];
        end
        ds = (vtx == 2'd1) || (r_tri && vtx == 2'd2);
        dt = (vtx == 2'd2) || (r_tri && vtx == 2'd0);

        n_busy = r_busy;
        n_tri  = r_tri;
        n_w    = r_w;
        load   = 1'b0;
        if (en) begin
            if (r_busy && !at_end) begin
                n_w = r_w + (r_wire ? 3'd1 : 3'd2);
            end else if (r_busy && !r_tri && r_has_b) begin
                n_tri = 1'b1;
                n_w   = '0;
            end else if (i_q_valid) begin
                load   = 1'b1;
                n_busy = 1'b1;
                n_tri  = !i_q_flags.has_a;
                n_w    = '0;
            end else begin
                n_busy = 1'b0;
            end
        end
        o_q_pop = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tri <= n_tri;
        r_w   <= n_w;
        if (load) begin
            r_row   <= i_q_row;
            r_col   <= i_q_col;
            r_has_b <= i_q_flags.has_b;
            r_wire  <= i_q_flags.wire_mode;
        end
    end

    // point pipeline
    logic [6:0]      r_v;
    logic [6:0]      r_l;
    logic [CB:0]     r_s0;
    logic [CB:0]     r_t0;
    logic [KW-1:0]   np;
    logic [KW-1:0]   na;
    logic [KW-1:0]   r_np1;
    logic [KW-1:0]   r_na1;
    logic [2*KW:0]   r_pp1;
    logic [2*KW:0]   r_pa1;
    logic [AB:0]     q0p;
    logic [AB:0]     q0a;
    logic [KW-1:0]   r_np2;
    logic [KW-1:0]   r_na2;
    logic [AB:0]     r_qp2;
    logic [AB:0]     r_qa2;
    logic [AB+CB:0]  r_dp2;
    logic [AB+CB:0]  r_da2;
    logic [KW-1:0]   remp;
    logic [KW-1:0]   rema;
    logic [AB:0]     polar;
    logic [AB:0]     azim;
    logic [AB-1:0]   r_elev3;
    logic [AB-1:0]   r_azim3;
    logic [15:0]     r_se4;
    logic [15:0]     r_ce4;
    logic [15:0]     r_sa4;
    logic [15:0]     r_ca4;
    logic [30:0]     r_rc5;
    logic [30:0]     r_rs5;
    logic [14:0]     r_ca5;
    logic [14:0]     r_sa5;
    logic [2:0]      r_sg5;
    logic [46:0]     px;
    logic [46:0]     py;
    logic [31:0]     pz;
    logic [16:0]     mx;
    logic [16:0]     my;
    logic [16:0]     mz;
    logic [16:0]     r_x;
    logic [16:0]     r_y;
    logic [16:0]     r_z;

    assign en = !r_v[6] || i_ready;

    always_comb begin
        np    = KW'({r_s0, {(AB-1){1'b0}}}) + KW'(i_stacks >> 1);
        na    = KW'({r_t0, {AB{1'b0}}}) + KW'(i_sectors >> 1);
        q0p   = r_pp1[KW+AB:KW];
        q0a   = r_pa1[KW+AB:KW];
        remp  = r_np2 - KW'(r_dp2);
        rema  = r_na2 - KW'(r_da2);
        polar = r_qp2 + (AB+1)'(remp >= KW'(i_stacks));
        azim  = r_qa2 + (AB+1)'(rema >= KW'(i_sectors));
        px    = 47'(r_rc5 * r_ca5) + (47'(1) << 29);
        py    = 47'(r_rc5 * r_sa5) + (47'(1) << 29);
        pz    = 32'(r_rs5) + (32'(1) << 14);
        mx    = {1'b0, px[45:30]};
        my    = {1'b0, py[45:30]};
        mz    = {1'b0, pz[30:15]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:0], r_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l     <= {r_l[5:0], at_end && (r_tri || !r_has_b)};
            r_s0    <= (CB+1)'(r_row) + (CB+1)'(ds);
            r_t0    <= (CB+1)'(r_col) + (CB+1)'(dt);
            r_np1   <= np;
            r_na1   <= na;
            r_pp1   <= np * i_rec_stacks;
            r_pa1   <= na * i_rec_sectors;
            r_np2   <= r_np1;
            r_na2   <= r_na1;
            r_qp2   <= q0p;
            r_qa2   <= q0a;
            r_dp2   <= q0p * i_stacks;
            r_da2   <= q0a * i_sectors;
            r_elev3 <= QUARTER - polar[AB-1:0];
            r_azim3 <= azim[AB-1:0];
            r_se4   <= phase_sine(r_elev3);
            r_ce4   <= phase_sine(r_elev3 + QUARTER);
            r_sa4   <= phase_sine(r_azim3);
            r_ca4   <= phase_sine(r_azim3 + QUARTER);
            r_rc5   <= i_radius * r_ce4[14:0];
            r_rs5   <= i_radius * r_se4[14:0];
            r_ca5   <= r_ca4[14:0];
            r_sa5   <= r_sa4[14:0];
            r_sg5   <= {r_se4[15], r_ce4[15] ^ r_sa4[15], r_ce4[15] ^ r_ca4[15]};
            r_x     <= r_sg5[0] ? -mx : mx;
            r_y     <= r_sg5[1] ? -my : my;
            r_z     <= r_sg5[2] ? -mz : mz;
        end
    end

    assign o_valid = r_v[6];
    assign o_last  = r_l[6];
    assign o_data  = {5'b0, r_z, r_y, r_x};

endmodule

[src/uv_sphere_quad_tessellator_top.sv]
// Channel   Dir  Fields
// s_axis    in   tdata: stack_index[7:0], sector_index[15:8]
// m_axis    out  tdata: pos_x[16:0], pos_y[33:17], pos_z[50:34]; tlast: last vertex of quad
// cfg       in   index 0 radius, 1 sector_count, 2 stack_count, 3 wire_mode
//
// One vertex per cycle on m_axis while it is not stalled and quads are queued; a quad gives
// 3 to 12 vertices, set by the vertex sequencer. After reset and after every cfg write,
// s_axis is held off while the serial reciprocal units rebuild. Out-of-range quads are
// taken and dropped. A stalled m_axis freezes the point pipeline; the quad queue keeps
// s_axis open until it is full.
module uv_sphere_quad_tessellator_top import sqt_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // stack_index, sector_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pos_x, pos_y, pos_z, zero pad
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int KW = COUNT_BITS + 1 + ANGLE_BITS;
    localparam int QW = 2 * COUNT_BITS + 3;

    logic [15:0]           r_radius;
    logic [COUNT_BITS-1:0] r_sectors;
    logic [COUNT_BITS-1:0] r_stacks;
    logic                  r_wire;
    logic                  cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_RST;
            r_sectors <= COUNT_BITS'(SECTORS_RST);
            r_stacks  <= COUNT_BITS'(STACKS_RST);
            r_wire    <= 1'b0;
        end else if (cfg_wr) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_RADIUS:  r_radius  <= i_cfg_data;
                CFG_SECTORS: r_sectors <= i_cfg_data[COUNT_BITS-1:0];
                CFG_STACKS:  r_stacks  <= i_cfg_data[COUNT_BITS-1:0];
                CFG_WIRE:    r_wire    <= i_cfg_data[0];
                default:     r_wire    <= r_wire;
            endcase
        end
    end

    logic              busy_sec;
    logic              busy_stk;
    logic [KW:0]       rec_sec;
    logic [KW:0]       rec_stk;

    sqt_recip #(.CB(COUNT_BITS), .KW(KW)) u_rec_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_wr),
        .i_div   (r_sectors),
        .o_busy  (busy_sec),
        .o_recip (rec_sec)
    );

    sqt_recip #(.CB(COUNT_BITS), .KW(KW)) u_rec_stk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_wr),
        .i_div   (r_stacks),
        .o_busy  (busy_stk),
        .o_recip (rec_stk)
    );

    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_empty;
    logic [COUNT_BITS-1:0] f_row;
    logic [COUNT_BITS-1:0] f_col;
    t_quad_flags           f_flags;
    logic [QW-1:0]         q_out;
    t_quad_flags           b_flags;

    sqt_front #(.CB(COUNT_BITS)) u_front (
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_sectors    (r_sectors),
        .i_stacks     (r_stacks),
        .i_wire       (r_wire),
        .i_recip_busy (busy_sec || busy_stk),
        .i_q_full     (q_full),
        .o_ready      (s_axis_tready),
        .o_push       (push),
        .o_row        (f_row),
        .o_col        (f_col),
        .o_flags      (f_flags)
    );

    sqt_fifo #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   ({f_row, f_col, f_flags}),
        .i_pop   (pop),
        .o_dout  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_flags = t_quad_flags'(q_out[2:0]);

    sqt_back #(.CB(COUNT_BITS), .AB(ANGLE_BITS), .KW(KW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (!q_empty),
        .i_q_row       (q_out[QW-1:COUNT_BITS+3]),
        .i_q_col       (q_out[COUNT_BITS+2:3]),
        .i_q_flags     (b_flags),
        .o_q_pop       (pop),
        .i_radius      (r_radius),
        .i_sectors     (r_sectors),
        .i_stacks      (r_stacks),
        .i_rec_sectors (rec_sec),
        .i_rec_stacks  (rec_stk),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule

[verif/tb.sv]
module tb;
    import sqt_pkg::*;

    typedef struct {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic        last;
    } t_vertex;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    uv_sphere_quad_tessellator_top u_top (.*);

    t_vertex     vertex_q[$];
    logic [15:0] sine_lut [0:256];
    int unsigned mdl_radius, mdl_sectors, mdl_stacks, mdl_wire;
    int          errors;
    int          stall_left;
    int          idle_cycles;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_err(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function automatic void build_lut();
        longint unsigned x, x2, term, q;
        longint sum;
        for (int k = 0; k <= 256; k++) begin
            x    = (64'(k) * PI_Q30) / 64'd512;
            term = x;
            sum  = signed'(x);
            x2   = (x * x) >> 30;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - signed'(term);
                else sum = sum + signed'(term);
            end
            q = (unsigned'(sum) + 64'd16384) >> 15;
            if (q > 64'd32767) q = 64'd32767;
            sine_lut[k] = 16'(q);
        end
    endfunction

    function automatic int phase_sin(input longint unsigned p);
        longint unsigned quad, q, idx, frac;
        int unsigned a, b, m;
        p    = p & 64'hFFFF;
        quad = p >> 14;
        q    = p & 64'h3FFF;
        if (quad[0]) q = 64'h4000 - q;
        idx  = q >> 6;
        frac = q & 64'h3F;
        if (idx >= 256) begin
            m = sine_lut[256];
        end else begin
            a = sine_lut[idx];
            b = sine_lut[idx + 1];
            m = a + int'((64'(b - a) * frac) >> 6);
        end
        return (quad >= 2) ? -int'(m) : int'(m);
    endfunction

    function automatic logic [16:0] mul3(input int a, input int b);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = (64'(mdl_radius) * ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? 17'(-m) : 17'(m);
    endfunction

    function automatic logic [16:0] mul2(input int a);
        longint unsigned ma, m;
        ma = (a < 0) ? -a : a;
        m  = (64'(mdl_radius) * ma + 64'd16384) >> 15;
        return (a < 0) ? 17'(-m) : 17'(m);
    endfunction

    function automatic t_vertex grid_point(input int unsigned s, input int unsigned t);
        longint unsigned polar, elev, azim;
        int se, ce, sa, ca;
        t_vertex v;
        polar = (64'(s) * 64'd32768 + mdl_stacks / 2) / mdl_stacks;
        elev  = (64'h4000 + 64'h10000 - (polar & 64'hFFFF)) & 64'hFFFF;
        azim  = (64'(t) * 64'h10000 + mdl_sectors / 2) / mdl_sectors;
        se = phase_sin(elev);
        ce = phase_sin(elev + 64'h4000);
        sa = phase_sin(azim);
        ca = phase_sin(azim + 64'h4000);
        v.x = mul3(ce, ca);
        v.y = mul3(ce, sa);
        v.z = mul2(se);
        v.last = 1'b0;
        return v;
    endfunction

    function automatic void predict_quad(input int unsigned i, input int unsigned j);
        int unsigned pts[12][2];
        int unsigned corner[3][2];
        int n;
        t_vertex v;
        n = 0;
        if (i >= mdl_stacks || j >= mdl_sectors) return;
        for (int half = 0; half < 2; half++) begin
            if (half == 0 && i == 0) continue;
            if (half == 1 && i == mdl_stacks - 1) continue;
            if (half == 0) corner = '{'{i, j}, '{i + 1, j}, '{i, j + 1}};
            else corner = '{'{i, j + 1}, '{i + 1, j}, '{i + 1, j + 1}};
            for (int k = 0; k < 3; k++) begin
                pts[n] = corner[k];
                n++;
                if (mdl_wire != 0) begin
                    pts[n] = corner[(k + 1) % 3];
                    n++;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            v = grid_point(pts[k][0], pts[k][1]);
            v.last = (k == n - 1);
            vertex_q.insert(vertex_q.size(), v);
        end
    endfunction

    // output side: check and random back-pressure
    always @(posedge i_clk) begin
        t_vertex e;
        int      w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (vertex_q.size() == 0) begin
                report_err($sformatf("unexpected vertex %h", m_axis_tdata));
            end else begin
                e = vertex_q.pop_front();
                if (m_axis_tdata[16:0] !== e.x)
                    report_err($sformatf("pos_x %h exp %h", m_axis_tdata[16:0], e.x));
                if (m_axis_tdata[33:17] !== e.y)
                    report_err($sformatf("pos_y %h exp %h", m_axis_tdata[33:17], e.y));
                if (m_axis_tdata[50:34] !== e.z)
                    report_err($sformatf("pos_z %h exp %h", m_axis_tdata[50:34], e.z));
                if (m_axis_tlast !== e.last)
                    report_err($sformatf("tlast %b exp %b", m_axis_tlast, e.last));
            end
            w = no_idle ? 0 : $urandom_range(0, 13);
            stall_left <= w;
            if (w > 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (stall_left <= 1) m_axis_tready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 3000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_quad(input int unsigned i, input int unsigned j);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {j[7:0], i[7:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_quad(i, j);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS:  mdl_radius  = val & 16'hFFFF;
            CFG_SECTORS: mdl_sectors = val & 8'hFF;
            CFG_STACKS:  mdl_stacks  = val & 8'hFF;
            default:     mdl_wire    = val & 1;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_sphere(input int unsigned r, input int unsigned sec,
                              input int unsigned stk, input int unsigned wmode);
        drain();
        cfg_write(CFG_RADIUS, r);
        cfg_write(CFG_SECTORS, sec);
        cfg_write(CFG_STACKS, stk);
        cfg_write(CFG_WIRE, wmode);
    endtask

    task automatic test_defaults();
        send_quad(0, 0);
        send_quad(5, 7);
        send_quad(17, 35);
        send_quad(18, 0);
        send_quad(0, 36);
        send_quad(255, 255);
    endtask

    task automatic test_directed();
        set_sphere(65535, 255, 255, 1);
        send_quad(0, 0);
        send_quad(254, 254);
        send_quad(127, 128);
        send_quad(255, 0);
        set_sphere(0, 1, 2, 0);
        send_quad(0, 0);
        send_quad(1, 0);
        send_quad(0, 1);
        set_sphere(256, 4, 1, 1);
        send_quad(0, 0);
        send_quad(0, 3);
        set_sphere(40000, 3, 3, 1);
        send_quad(0, 2);
        send_quad(1, 2);
        send_quad(2, 2);
    endtask

    task automatic test_random();
        int unsigned r, sec, stk, i, j;
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0: r = 0;
                1: r = 65535;
                default: r = $urandom_range(0, 65535);
            endcase
            sec = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 64);
            stk = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 40);
            set_sphere(r, sec, stk, $urandom_range(0, 1));
            no_idle = (ph % 4 == 3);
            for (int n = 0; n < 25; n++) begin
                if ($urandom_range(0, 6) == 0) begin
                    i = $urandom_range(0, 255);
                    j = $urandom_range(0, 255);
                end else begin
                    i = $urandom_range(0, stk - 1);
                    j = $urandom_range(0, sec - 1);
                end
                if (n == 12 && ph == 4) drain();
                send_quad(i, j);
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        build_lut();
        errors        = 0;
        no_idle       = 1'b0;
        idle_cycles   = 0;
        mdl_radius    = 256;
        mdl_sectors   = 36;
        mdl_stacks    = 18;
        mdl_wire      = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_RADIUS;
        i_cfg_data    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_directed();
        test_random();
        drain();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[uv_sphere_quad_tessellator_top.f]
src/sqt_pkg.sv
src/sqt_recip.sv
src/sqt_fifo.sv
src/sqt_front.sv
src/sqt_back.sv
src/uv_sphere_quad_tessellator_top.sv
verif/tb.sv
